FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker modules.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/irdpa_pkg.sv
// Package for the IR distance polynomial averager: register map,
// coefficient reset values, arithmetic constants and sequencer states.
// No dependencies.
package irdpa_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_C0 = 3'd0;
  localparam logic [2:0] REG_C1 = 3'd1;
  localparam logic [2:0] REG_C2 = 3'd2;
  localparam logic [2:0] REG_C3 = 3'd3;
  localparam logic [2:0] REG_C4 = 3'd4;

  // coefficient reset values, Q12
  localparam logic signed [15:0] C0_RST = 16'sd9585;
  localparam logic signed [15:0] C1_RST = -16'sd19415;
  localparam logic signed [15:0] C2_RST = 16'sd16630;
  localparam logic signed [15:0] C3_RST = -16'sd6554;
  localparam logic signed [15:0] C4_RST = 16'sd983;

  // volts = (code * 135168 + 5115) / 10230, 14 quotient bits
  localparam int VOLT_BIAS   = 5115;
  localparam int VOLT_DEN    = 10230;
  localparam int VOLT_QW     = 14;
  localparam int VOLT_NW     = 28;
  // average magnitude never exceeds 800: 10 quotient bits
  localparam int AVG_QW      = 10;

  // Horner accumulator and product widths
  localparam int ACC_W       = 26;
  localparam int PROD_W      = ACC_W + VOLT_QW;
  localparam int Q12_HALF    = 2048;
  localparam int DIST_MAX    = 32767;
  localparam int DIST_MIN    = -32768;

  localparam int DEF_RING_DEPTH = 16;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_VDIV  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_APREP = 8'b0010_0000,
    S_ADIV  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

FILE: hdl/ir_distance_poly_averager.sv
// IR distance linearizer with moving average: top level.
// Depends on irdpa_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_sample_code) takes one 10-bit
//   converter code per transfer. Output channel (out_valid/out_ready) gives
//   the Q12 distance and the mean of the last RING_DEPTH distances in cm.
//   Coefficients c0..c4 sit on the APB port at byte addresses 0,4,..,16;
//   write them only while the block is idle.
//   The bit-serial datapath works in order: the volts division, 4 Horner
//   steps (each a shift-add multiply plus round/add), the ring and sum
//   update, the set-up and run of the average division, and the load of
//   the output register. The next item is taken once the previous result
//   sits in the output register.
//   Reset (rst_n low, synchronous) restores default coefficients and empties
//   the ring. If the receiver stalls, the result is held in the output
//   register; a following item is still computed but waits in the last
//   sequencer state until the output register frees.
module ir_distance_poly_averager
  import irdpa_pkg::*;
#(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          in_sample_code,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_distance_q12,
  output logic signed [10:0]  out_average_cm,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int PTRW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILLW = $clog2(RING_DEPTH + 1);
  localparam int SUMW  = 16 + $clog2(RING_DEPTH);
  localparam int AVGNW = SUMW + 7;
  localparam int AVGDW = FILLW + 12 + AVG_QW - 1;
  localparam int DW0   = (VOLT_NW > AVGNW) ? VOLT_NW : AVGNW;
  localparam int DW    = (DW0 > AVGDW) ? DW0 : AVGDW;
  localparam int VOLT_DSH = VOLT_DEN * (2 ** (VOLT_QW - 1));

  // configuration registers
  logic signed [15:0] coef_r [5];
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_C0] <= C0_RST;
      coef_r[REG_C1] <= C1_RST;
      coef_r[REG_C2] <= C2_RST;
      coef_r[REG_C3] <= C3_RST;
      coef_r[REG_C4] <= C4_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_C0:  coef_r[REG_C0] <= pwdata[15:0];
        REG_C1:  coef_r[REG_C1] <= pwdata[15:0];
        REG_C2:  coef_r[REG_C2] <= pwdata[15:0];
        REG_C3:  coef_r[REG_C3] <= pwdata[15:0];
        REG_C4:  coef_r[REG_C4] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback, sign-extended
  always_comb begin
    case (reg_idx)
      REG_C0:  prdata = 32'(coef_r[REG_C0]);
      REG_C1:  prdata = 32'(coef_r[REG_C1]);
      REG_C2:  prdata = 32'(coef_r[REG_C2]);
      REG_C3:  prdata = 32'(coef_r[REG_C3]);
      REG_C4:  prdata = 32'(coef_r[REG_C4]);
      default: prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  state_t                    state_r, state_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [1:0]                k_r, k_nxt;
  logic [DW-1:0]             rem_r, rem_nxt;
  logic [DW-1:0]             dsh_r, dsh_nxt;
  logic [VOLT_QW-1:0]        quo_r, quo_nxt;
  logic [VOLT_QW-1:0]        v_r, v_nxt;
  logic [VOLT_QW-1:0]        mpl_r, mpl_nxt;
  logic signed [PROD_W-1:0]  mcand_r, mcand_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [15:0]        dist_r, dist_nxt;
  logic signed [SUMW-1:0]    sum_r, sum_nxt;
  logic [PTRW-1:0]           wp_r, wp_nxt;
  logic [FILLW-1:0]          fill_r, fill_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [15:0]        old_r;
  logic                      out_valid_r;
  logic signed [15:0]        out_dist_r;
  logic signed [10:0]        out_avg_r;

  logic signed [15:0]        ring [RING_DEPTH];

  logic                      in_xfer, ring_wr, out_load, full;
  logic                      div_ge;
  logic [DW-1:0]             div_diff;
  logic [VOLT_QW-1:0]        div_quo;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [15:0]        dist_sat;
  logic [SUMW-1:0]           sum_mag;
  logic [AVG_QW:0]           avg_mag;
  logic signed [10:0]        avg_val;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign full      = (fill_r == FILLW'(RING_DEPTH));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign ring_wr   = (state_r == S_UPD);

  // shared restoring division step: one quotient bit per cycle
  assign div_ge   = (rem_r >= dsh_r);
  assign div_diff = rem_r - dsh_r;
  assign div_quo  = {quo_r[VOLT_QW-2:0], div_ge};

  // rounding of the Q24 product to Q12, halves up
  assign prod_rnd = (prod_r + PROD_W'(Q12_HALF)) >>> 12;

  // distance saturation
  always_comb begin
    if (acc_r > ACC_W'(DIST_MAX)) begin
      dist_sat = 16'(DIST_MAX);
    end else if (acc_r < ACC_W'(DIST_MIN)) begin
      dist_sat = 16'(DIST_MIN);
    end else begin
      dist_sat = acc_r[15:0];
    end
  end

  // finished quotient of the average division sits in quo_r
  assign sum_mag = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign avg_mag = {1'b0, quo_r[AVG_QW-1:0]};
  assign avg_val = neg_r ? -$signed(avg_mag) : $signed(avg_mag);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    v_nxt     = v_r;
    mpl_nxt   = mpl_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    dist_nxt  = dist_r;
    sum_nxt   = sum_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    neg_nxt   = neg_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // code * 135168 + 5115 as shifts and adds
          rem_nxt   = DW'({in_sample_code, 17'b0}) + DW'({in_sample_code, 12'b0})
                      + DW'(VOLT_BIAS);
          dsh_nxt   = DW'(VOLT_DSH);
          quo_nxt   = '0;
          cnt_nxt   = 4'(VOLT_QW - 1);
          state_nxt = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_ge) rem_nxt = div_diff;
        dsh_nxt = dsh_r >> 1;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          // start Horner with c4
          v_nxt     = div_quo;
          mpl_nxt   = div_quo;
          acc_nxt   = ACC_W'(coef_r[REG_C4]);
          mcand_nxt = PROD_W'(coef_r[REG_C4]);
          prod_nxt  = '0;
          k_nxt     = 2'd3;
          cnt_nxt   = 4'(VOLT_QW - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // shift-add over the volts bits, LSB first
        if (mpl_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt = mcand_r <<< 1;
        mpl_nxt   = mpl_r >> 1;
        cnt_nxt   = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = S_ADD;
      end
      S_ADD: begin
        acc_nxt = ACC_W'(prod_rnd) + ACC_W'(coef_r[{1'b0, k_r}]);
        if (k_r == 2'd0) begin
          state_nxt = S_UPD;
        end else begin
          k_nxt     = k_r - 2'd1;
          mpl_nxt   = v_r;
          mcand_nxt = PROD_W'(ACC_W'(prod_rnd) + ACC_W'(coef_r[{1'b0, k_r}]));
          prod_nxt  = '0;
          cnt_nxt   = 4'(VOLT_QW - 1);
          state_nxt = S_MUL;
        end
      end
      S_UPD: begin
        // ring write, running sum with evicted entry once full
        dist_nxt = dist_sat;
        sum_nxt  = sum_r - (full ? SUMW'(old_r) : SUMW'(0)) + SUMW'(dist_sat);
        wp_nxt   = (wp_r == PTRW'(RING_DEPTH - 1)) ? '0 : wp_r + PTRW'(1);
        if (!full) fill_nxt = fill_r + FILLW'(1);
        state_nxt = S_APREP;
      end
      S_APREP: begin
        // |sum| * 100 over fill * 4096
        rem_nxt   = DW'({sum_mag, 6'b0}) + DW'({sum_mag, 5'b0}) + DW'({sum_mag, 2'b0});
        dsh_nxt   = DW'({fill_r, 12'b0, (AVG_QW - 1)'(0)});
        neg_nxt   = sum_r[SUMW-1];
        quo_nxt   = '0;
        cnt_nxt   = 4'(AVG_QW - 1);
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        if (div_ge) rem_nxt = div_diff;
        dsh_nxt = dsh_r >> 1;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    quo_r   <= quo_nxt;
    v_r     <= v_nxt;
    mpl_r   <= mpl_nxt;
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    dist_r  <= dist_nxt;
    neg_r   <= neg_nxt;
    if (out_load) begin
      out_dist_r <= dist_r;
      out_avg_r  <= avg_val;
    end
  end

  // sample ring: entry under the write pointer read at input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) old_r <= ring[wp_r];
    if (ring_wr) ring[wp_r] <= dist_sat;
  end

  assign out_valid        = out_valid_r;
  assign out_distance_q12 = out_dist_r;
  assign out_average_cm   = out_avg_r;

endmodule

FILE: hdl/irdpa_checker.sv
// Port-level checker for ir_distance_poly_averager, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module irdpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_distance_q12,
  input logic signed [10:0] out_average_cm,
  input logic              pready
);

  // a stalled result stays valid and unchanged
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_distance_q12) && $stable(out_average_cm), "result changed while stalled")

  // after an input transfer the block is busy
  `ASSERT_CLK(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // mean stays within the centimetre range
  `ASSERT_CLK(a_avg_rng, clk, rst_n, out_valid |-> out_average_cm >= -11'sd800 && out_average_cm <= 11'sd799, "average out of range")

  // configuration port never waits
  `ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind ir_distance_poly_averager irdpa_checker u_irdpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_distance_q12 (out_distance_q12),
  .out_average_cm   (out_average_cm),
  .pready           (pready)
);
